### rtl/core/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// concurrent assertion on the block clock and reset
`define ASSERT_DEF(label, prop) \
   `ASSERT_RST(label, clock, reset, prop)

`endif

### rtl/core/sdf_pkg.sv
// shared types, codes and the crc step of the packet deframer
`default_nettype none

package sdf_pkg;

   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_LEN  = 3'd1,
      PH_ID   = 3'd2,
      PH_CMD  = 3'd3,
      PH_PAY  = 3'd4,
      PH_CRCL = 3'd5,
      PH_CRCH = 3'd6
   } phase_type;

   localparam logic [2:0] ST_BUSY   = 3'd0;
   localparam logic [2:0] ST_OK     = 3'd1;
   localparam logic [2:0] ST_SIGERR = 3'd2;
   localparam logic [2:0] ST_CRCERR = 3'd3;
   localparam logic [2:0] ST_LENERR = 3'd4;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ID   = 2'd1;
   localparam logic [1:0] KIND_PAY  = 2'd2;

   localparam logic [1:0] REG_SIG_LEN   = 2'd0;
   localparam logic [1:0] REG_SIG_VALUE = 2'd1;
   localparam logic [1:0] REG_CRC_INIT  = 2'd2;

   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } head_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [63:0] data;
   } csr_write_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/core/signed_packet_deframer_crc16_unit.sv
// an accepted byte goes through the byte queue and the result register to the result side
// throughput: one byte per cycle unless stalled, set by the engine's combinational crc
// a four-entry byte queue lets the input keep flowing while a result waits on rsp_stall
// reset: synchronous, restores state and config registers and empties the queue at once
// configuration writes complete in the cycle they are presented
`default_nettype none

module signed_packet_deframer_crc16_unit #(
   parameter int MAX_SIG_BYTES = 8,
   parameter int ID_BYTES      = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_command,
   output logic [31:0]      rsp_frame_length,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   sdf_pkg::head_type       head;
   sdf_pkg::csr_write_type  csr_wr;
   logic                    pop;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   sdf_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .head_o        (head),
      .pop_i         (pop)
   );

   sdf_engine #(
      .MAX_SIG_BYTES (MAX_SIG_BYTES),
      .ID_BYTES      (ID_BYTES)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .head_i           (head),
      .pop_o            (pop),
      .csr_i            (csr_wr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_status       (rsp_status),
      .rsp_command      (rsp_command),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule

`default_nettype wire

### rtl/core/sdf_queue.sv
// front side: accepts bytes into a short queue ahead of the deframing engine
`default_nettype none
`include "assert_macros.svh"

module sdf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_data_byte,
   output sdf_pkg::head_type      head_o,
   input  wire logic              pop_i
);

   logic [7:0]                    mem_ff [sdf_pkg::QUEUE_DEPTH];
   logic [sdf_pkg::QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [sdf_pkg::QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [sdf_pkg::QUEUE_AW:0]    count_ff, count_in;
   logic                          push;

   always_comb begin
      req_stall    = (count_ff == (sdf_pkg::QUEUE_AW+1)'(sdf_pkg::QUEUE_DEPTH));
      push         = req_valid && !req_stall;
      head_o.valid = (count_ff != '0);
      head_o.data  = mem_ff[rd_ptr_ff];
      wr_ptr_in    = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop_i ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (push && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data_byte;
      end
   end

   `ASSERT_DEF(a_pop_not_empty, pop_i |-> (count_ff != '0))

endmodule

`default_nettype wire

### rtl/core/sdf_engine.sv
// back side: frame parsing, crc check and the result register
`default_nettype none
`include "assert_macros.svh"

module sdf_engine #(
   parameter int MAX_SIG_BYTES = 8,
   parameter int ID_BYTES      = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sdf_pkg::head_type      head_i,
   output logic                        pop_o,
   input  wire sdf_pkg::csr_write_type csr_i,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_out_kind,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_frame_end,
   output logic [2:0]                  rsp_status,
   output logic [15:0]                 rsp_command,
   output logic [31:0]                 rsp_frame_length
);

   logic [3:0]          sig_len_ff;
   logic [63:0]         sig_value_ff;
   logic [15:0]         crc_init_ff;

   sdf_pkg::phase_type  phase_ff, phase_in, ph;
   logic [31:0]         count_ff, count_in;
   logic [15:0]         crc_ff, crc_in;
   logic [31:0]         length_ff, length_in;
   logic [15:0]         cmd_ff, cmd_in;
   logic [7:0]          crc_low_ff, crc_low_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          kind_ff, kind_in;
   logic [7:0]          obyte_ff, obyte_in;
   logic                fend_ff, fend_in;
   logic [2:0]          status_ff, status_in;
   logic [15:0]         ocmd_ff, ocmd_in;
   logic [31:0]         olen_ff, olen_in;

   logic                fire;
   logic                restart;
   logic [3:0]          s;
   logic [31:0]         s_wide, hdr_end, id_end, cmd_end;
   logic [31:0]         cnt_inc, len_rel, cmd_rel;
   logic [7:0]          b;
   logic [15:0]         crc_next;
   logic [31:0]         len_new;
   logic [15:0]         cmd_new;
   logic                pay_done;

   always_comb begin
      fire     = head_i.valid && (!rsp_valid_ff || !rsp_stall);
      pop_o    = fire;
      b        = head_i.data;
      s        = (sig_len_ff > 4'(MAX_SIG_BYTES)) ? 4'(MAX_SIG_BYTES) : sig_len_ff;
      s_wide   = {28'd0, s};
      hdr_end  = s_wide + 32'd4;
      id_end   = hdr_end + 32'(ID_BYTES);
      cmd_end  = id_end + 32'd2;
      cnt_inc  = count_ff + 32'd1;
      len_rel  = count_ff - s_wide;
      cmd_rel  = count_ff - id_end;
      crc_next = sdf_pkg::crc_byte(crc_ff, b);
      len_new  = length_ff | ({24'd0, b} << {len_rel[1:0], 3'b000});
      cmd_new  = cmd_ff | ({8'd0, b} << {cmd_rel[0], 3'b000});
      pay_done = (length_ff < 32'd2) || (cnt_inc >= length_ff - 32'd2);
      ph       = (phase_ff == sdf_pkg::PH_SIG && count_ff >= s_wide) ?
                 sdf_pkg::PH_LEN : phase_ff;

      phase_in   = phase_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      length_in  = length_ff;
      cmd_in     = cmd_ff;
      crc_low_in = crc_low_ff;
      restart    = 1'b0;
      kind_in    = sdf_pkg::KIND_NONE;
      obyte_in   = 8'd0;
      fend_in    = 1'b0;
      status_in  = sdf_pkg::ST_BUSY;
      ocmd_in    = 16'd0;
      olen_in    = 32'd0;

      if (fire) begin
         phase_in = ph;
         case (ph)
            sdf_pkg::PH_SIG: begin
               if (b != sig_value_ff[{count_ff[2:0], 3'b000} +: 8]) begin
                  fend_in   = 1'b1;
                  status_in = sdf_pkg::ST_SIGERR;
                  ocmd_in   = cmd_ff;
                  olen_in   = length_ff;
                  restart   = 1'b1;
               end else begin
                  crc_in   = crc_next;
                  count_in = cnt_inc;
                  if (cnt_inc >= s_wide) begin
                     phase_in = sdf_pkg::PH_LEN;
                  end
               end
            end
            sdf_pkg::PH_LEN: begin
               length_in = len_new;
               crc_in    = crc_next;
               count_in  = cnt_inc;
               if (cnt_inc >= hdr_end) begin
                  if (len_new < cmd_end + 32'd2) begin
                     fend_in   = 1'b1;
                     status_in = sdf_pkg::ST_LENERR;
                     ocmd_in   = cmd_ff;
                     olen_in   = len_new;
                     restart   = 1'b1;
                  end else begin
                     phase_in = sdf_pkg::PH_ID;
                  end
               end
            end
            sdf_pkg::PH_ID: begin
               kind_in  = sdf_pkg::KIND_ID;
               obyte_in = b;
               crc_in   = crc_next;
               count_in = cnt_inc;
               if (cnt_inc >= id_end) begin
                  phase_in = sdf_pkg::PH_CMD;
               end
            end
            sdf_pkg::PH_CMD: begin
               cmd_in   = cmd_new;
               crc_in   = crc_next;
               count_in = cnt_inc;
               if (cnt_inc >= cmd_end) begin
                  phase_in = pay_done ? sdf_pkg::PH_CRCL : sdf_pkg::PH_PAY;
               end
            end
            sdf_pkg::PH_PAY: begin
               kind_in  = sdf_pkg::KIND_PAY;
               obyte_in = b;
               crc_in   = crc_next;
               count_in = cnt_inc;
               if (pay_done) begin
                  phase_in = sdf_pkg::PH_CRCL;
               end
            end
            sdf_pkg::PH_CRCL: begin
               crc_low_in = b;
               count_in   = cnt_inc;
               phase_in   = sdf_pkg::PH_CRCH;
            end
            default: begin
               fend_in   = 1'b1;
               status_in = ({b, crc_low_ff} == crc_ff) ? sdf_pkg::ST_OK : sdf_pkg::ST_CRCERR;
               ocmd_in   = cmd_ff;
               olen_in   = length_ff;
               restart   = 1'b1;
            end
         endcase
      end

      if (restart) begin
         phase_in   = sdf_pkg::PH_SIG;
         count_in   = 32'd0;
         crc_in     = crc_init_ff;
         length_in  = 32'd0;
         cmd_in     = 16'd0;
         crc_low_in = 8'd0;
      end

      // crc_init write also seeds an idle engine
      if (csr_i.valid && csr_i.index == sdf_pkg::REG_CRC_INIT &&
          phase_ff == sdf_pkg::PH_SIG && count_ff == 32'd0) begin
         crc_in = csr_i.data[15:0];
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_len_ff   <= 4'd4;
         sig_value_ff <= 64'd0;
         crc_init_ff  <= 16'd0;
      end else if (csr_i.valid) begin
         case (csr_i.index)
            sdf_pkg::REG_SIG_LEN:   sig_len_ff   <= csr_i.data[3:0];
            sdf_pkg::REG_SIG_VALUE: sig_value_ff <= csr_i.data;
            sdf_pkg::REG_CRC_INIT:  crc_init_ff  <= csr_i.data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sdf_pkg::PH_SIG;
         count_ff     <= 32'd0;
         crc_ff       <= 16'd0;
         length_ff    <= 32'd0;
         cmd_ff       <= 16'd0;
         crc_low_ff   <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         length_ff    <= length_in;
         cmd_ff       <= cmd_in;
         crc_low_ff   <= crc_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff   <= kind_in;
         obyte_ff  <= obyte_in;
         fend_ff   <= fend_in;
         status_ff <= status_in;
         ocmd_ff   <= ocmd_in;
         olen_ff   <= olen_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = kind_ff;
   assign rsp_out_byte     = obyte_ff;
   assign rsp_frame_end    = fend_ff;
   assign rsp_status       = status_ff;
   assign rsp_command      = ocmd_ff;
   assign rsp_frame_length = olen_ff;

   `ASSERT_DEF(a_fire_loads_rsp, fire |=> rsp_valid_ff)
   `ASSERT_DEF(a_crch_ends_frame, (fire && phase_ff == sdf_pkg::PH_CRCH) |=> fend_ff)
   `ASSERT_DEF(a_count_past_sig, (phase_ff != sdf_pkg::PH_SIG) |-> (count_ff != 32'd0))

endmodule

`default_nettype wire

### test/tb_signed_packet_deframer_crc16_unit.sv
// self-checking testbench for the crc16 packet deframer: directed table, then random frames
`timescale 1ns / 1ps

module tb_signed_packet_deframer_crc16_unit;

   localparam int MAX_SIG      = 8;
   localparam int ID_LEN       = 32;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_ITEMS  = 230;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        frame_end;
      logic [2:0]  status;
      logic [15:0] command;
      logic [31:0] frame_length;
   } deframe_out_type;

   typedef struct {
      logic [7:0]      b;
      bit              typed;
      deframe_out_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_command;
   logic [31:0] rsp_frame_length;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   // predictor copy of the block's registers and parse state
   logic [3:0]           cfg_sig_len;
   logic [63:0]          cfg_sig_value;
   logic [15:0]          cfg_crc_init;
   sdf_pkg::phase_type   st_phase;
   logic [31:0]          st_count;
   logic [15:0]          st_crc;
   logic [31:0]          st_length;
   logic [15:0]          st_command;
   logic [7:0]           st_crc_low;

   deframe_out_type deframed_q[$];
   stim_row_type    directed_rows[22];
   int              failures = 0;
   int              items_sent = 0;
   int              send_idle_pct = 38;
   int              stall_pct = 80;
   int              hold_asked = 0;
   int              hold_served = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;

   signed_packet_deframer_crc16_unit #(
      .MAX_SIG_BYTES(MAX_SIG),
      .ID_BYTES(ID_LEN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_kind(rsp_out_kind),
      .rsp_out_byte(rsp_out_byte),
      .rsp_frame_end(rsp_frame_end),
      .rsp_status(rsp_status),
      .rsp_command(rsp_command),
      .rsp_frame_length(rsp_frame_length),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] crc_arc(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      v = c ^ {8'h00, b};
      repeat (8) v = v[0] ? ((v >> 1) ^ sdf_pkg::CRC_POLY) : (v >> 1);
      return v;
   endfunction

   function automatic int eff_sig_len();
      return (cfg_sig_len > MAX_SIG) ? MAX_SIG : int'(cfg_sig_len);
   endfunction

   function automatic void frame_restart();
      st_phase   = sdf_pkg::PH_SIG;
      st_count   = '0;
      st_crc     = cfg_crc_init;
      st_length  = '0;
      st_command = '0;
      st_crc_low = '0;
   endfunction

   function automatic void note_csr(input logic [1:0] idx, input logic [63:0] d);
      case (idx)
         sdf_pkg::REG_SIG_LEN: cfg_sig_len = d[3:0];
         sdf_pkg::REG_SIG_VALUE: cfg_sig_value = d;
         sdf_pkg::REG_CRC_INIT: begin
            cfg_crc_init = d[15:0];
            if (st_phase == sdf_pkg::PH_SIG && st_count == 0) st_crc = cfg_crc_init;
         end
         default: ;
      endcase
   endfunction

   function automatic deframe_out_type deframe_step(input logic [7:0] b);
      deframe_out_type r;
      logic [31:0]     s, hdr_end, id_end, cmd_end, off;
      r = '0;
      r.kind = sdf_pkg::KIND_NONE;
      r.status = sdf_pkg::ST_BUSY;
      s = eff_sig_len();
      hdr_end = s + 4;
      id_end = hdr_end + ID_LEN;
      cmd_end = id_end + 2;
      if (st_phase == sdf_pkg::PH_SIG && st_count >= s) st_phase = sdf_pkg::PH_LEN;
      case (st_phase)
         sdf_pkg::PH_SIG: begin
            if (b != cfg_sig_value[{st_count[2:0], 3'b000} +: 8]) begin
               r.frame_end = 1'b1;
               r.status = sdf_pkg::ST_SIGERR;
               r.command = st_command;
               r.frame_length = st_length;
               frame_restart();
            end else begin
               st_crc = crc_arc(st_crc, b);
               st_count++;
               if (st_count >= s) st_phase = sdf_pkg::PH_LEN;
            end
         end
         sdf_pkg::PH_LEN: begin
            off = st_count - s;
            st_length = st_length | (32'(b) << {off[1:0], 3'b000});
            st_crc = crc_arc(st_crc, b);
            st_count++;
            if (st_count >= hdr_end) begin
               if (st_length < cmd_end + 2) begin
                  r.frame_end = 1'b1;
                  r.status = sdf_pkg::ST_LENERR;
                  r.command = st_command;
                  r.frame_length = st_length;
                  frame_restart();
               end else begin
                  st_phase = sdf_pkg::PH_ID;
               end
            end
         end
         sdf_pkg::PH_ID: begin
            r.kind = sdf_pkg::KIND_ID;
            r.data = b;
            st_crc = crc_arc(st_crc, b);
            st_count++;
            if (st_count >= id_end) st_phase = sdf_pkg::PH_CMD;
         end
         sdf_pkg::PH_CMD: begin
            off = st_count - id_end;
            st_command = st_command | (16'(b) << {off[0], 3'b000});
            st_crc = crc_arc(st_crc, b);
            st_count++;
            if (st_count >= cmd_end) begin
               if (st_length < 2 || st_count >= st_length - 2) st_phase = sdf_pkg::PH_CRCL;
               else st_phase = sdf_pkg::PH_PAY;
            end
         end
         sdf_pkg::PH_PAY: begin
            r.kind = sdf_pkg::KIND_PAY;
            r.data = b;
            st_crc = crc_arc(st_crc, b);
            st_count++;
            if (st_length < 2 || st_count >= st_length - 2) st_phase = sdf_pkg::PH_CRCL;
         end
         sdf_pkg::PH_CRCL: begin
            st_crc_low = b;
            st_count++;
            st_phase = sdf_pkg::PH_CRCH;
         end
         default: begin
            r.frame_end = 1'b1;
            r.status = ({b, st_crc_low} == st_crc) ? sdf_pkg::ST_OK : sdf_pkg::ST_CRCERR;
            r.command = st_command;
            r.frame_length = st_length;
            frame_restart();
         end
      endcase
      return r;
   endfunction

   function automatic stim_row_type dir_row(input logic [7:0] b, input bit typed,
                                            input logic [1:0] kind, input logic fend,
                                            input logic [2:0] status, input logic [31:0] flen);
      stim_row_type row;
      row.b = b;
      row.typed = typed;
      row.want = '0;
      row.want.kind = kind;
      row.want.data = (kind == sdf_pkg::KIND_NONE) ? 8'h00 : b;
      row.want.frame_end = fend;
      row.want.status = status;
      row.want.frame_length = flen;
      return row;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input deframe_out_type want = '0);
      deframe_out_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      pred = deframe_step(b);
      deframed_q.push_back(typed ? want : pred);
      items_sent++;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      note_csr(idx, d);
   endtask

   task automatic apply_settings(input logic [3:0] sl, input logic [63:0] sv,
                                 input logic [15:0] ci);
      csr_write(sdf_pkg::REG_SIG_LEN, {60'd0, sl});
      csr_write(sdf_pkg::REG_SIG_VALUE, sv);
      csr_write(sdf_pkg::REG_CRC_INIT, {48'd0, ci});
      csr_write(REG_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // feeds filler until the parser sits at a frame start; zeros keep a length field short
   task automatic resync_frame();
      while (!(st_phase == sdf_pkg::PH_SIG && st_count == 0)) begin
         if (st_phase == sdf_pkg::PH_LEN ||
             (st_phase == sdf_pkg::PH_SIG && st_count >= eff_sig_len()))
            send_byte(8'h00);
         else
            send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_random_frame();
      logic [7:0]  fb[$];
      logic [31:0] flen;
      logic [15:0] fcrc;
      logic [7:0]  bad;
      int          s, pick, npay, j;
      s = eff_sig_len();
      pick = $urandom_range(0, 99);
      npay = 0;
      if (s == 0 && pick >= 88) pick = $urandom_range(0, 87);
      if (pick < 88) begin
         for (j = 0; j < s; j++) fb.push_back(cfg_sig_value[8 * j +: 8]);
         if (pick < 78) begin
            npay = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 8);
            flen = s + 40 + npay;
         end else begin
            flen = $urandom_range(0, s + 39);
         end
         for (j = 0; j < 4; j++) fb.push_back(flen[8 * j +: 8]);
         if (pick < 78) begin
            for (j = 0; j < ID_LEN + 2 + npay; j++) fb.push_back(8'($urandom_range(0, 255)));
            fcrc = cfg_crc_init;
            foreach (fb[i]) fcrc = crc_arc(fcrc, fb[i]);
            // corrupted check word
            if (pick >= 68) fcrc = fcrc ^ (16'd1 << $urandom_range(0, 15));
            fb.push_back(fcrc[7:0]);
            fb.push_back(fcrc[15:8]);
         end
      end else if (pick < 95) begin
         j = $urandom_range(0, s - 1);
         for (int i = 0; i < j; i++) fb.push_back(cfg_sig_value[8 * i +: 8]);
         fb.push_back(cfg_sig_value[8 * j +: 8] ^ 8'($urandom_range(1, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            bad = 8'($urandom_range(0, 255));
            if (bad == cfg_sig_value[7:0]) bad = bad ^ 8'h01;
            fb.push_back(bad);
         end
      end
      foreach (fb[i]) send_byte(fb[i]);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic check_result();
      deframe_out_type want, got;
      got = {rsp_out_kind, rsp_out_byte, rsp_frame_end, rsp_status, rsp_command,
             rsp_frame_length};
      if (deframed_q.size() == 0) begin
         $display("%0t: unexpected item, expected none actual %h", $time, got);
         failures++;
      end else begin
         want = deframed_q.pop_front();
         compare_field("out_kind", 32'(want.kind), 32'(got.kind));
         compare_field("out_byte", 32'(want.data), 32'(got.data));
         compare_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("command", 32'(want.command), 32'(got.command));
         compare_field("frame_length", want.frame_length, got.frame_length);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result();
      if (hold_left == 0 && hold_served != hold_asked) begin
         hold_left = HOLD_CYCLES;
         hold_served++;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_signed_packet_deframer_crc16_unit NOT OK");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = sdf_pkg::REG_SIG_LEN;
      csr_data = 64'd0;
      cfg_sig_len = 4'd4;
      cfg_sig_value = 64'd0;
      cfg_crc_init = 16'd0;
      frame_restart();

      // reset config: four zero signature bytes
      directed_rows[0]  = dir_row(8'hFF, 1, sdf_pkg::KIND_NONE, 1'b1, sdf_pkg::ST_SIGERR, 32'd0);
      for (int i = 1; i <= 4; i++)
         directed_rows[i] = dir_row(8'h00, 1, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[5]  = dir_row(8'h05, 1, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[6]  = dir_row(8'h00, 1, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[7]  = dir_row(8'h00, 1, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[8]  = dir_row(8'h00, 1, sdf_pkg::KIND_NONE, 1'b1, sdf_pkg::ST_LENERR, 32'd5);
      directed_rows[9]  = dir_row(8'h01, 1, sdf_pkg::KIND_NONE, 1'b1, sdf_pkg::ST_SIGERR, 32'd0);
      for (int i = 10; i <= 13; i++)
         directed_rows[i] = dir_row(8'h00, 1, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      // shortest legal length, frame is left open across the next register writes
      directed_rows[14] = dir_row(8'h2C, 0, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[15] = dir_row(8'h00, 0, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[16] = dir_row(8'h00, 0, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[17] = dir_row(8'h00, 0, sdf_pkg::KIND_NONE, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[18] = dir_row(8'h00, 1, sdf_pkg::KIND_ID, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[19] = dir_row(8'hFF, 1, sdf_pkg::KIND_ID, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[20] = dir_row(8'h80, 0, sdf_pkg::KIND_ID, 1'b0, sdf_pkg::ST_BUSY, 32'd0);
      directed_rows[21] = dir_row(8'h7F, 0, sdf_pkg::KIND_ID, 1'b0, sdf_pkg::ST_BUSY, 32'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);

      for (int p = 1; p <= 7; p++) begin
         wait_drained();
         if (p == 3) begin
            send_idle_pct = 80;
            stall_pct = 38;
         end
         if (p == 5) begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         case (p)
            1: apply_settings(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
            2: apply_settings(4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
            3: apply_settings(4'd15, {$urandom, $urandom}, 16'($urandom));
            4: apply_settings(4'd1, 64'd0, 16'hFFFF);
            5: apply_settings(4'd4, {$urandom, $urandom}, 16'h0000);
            6: apply_settings(4'($urandom_range(0, 15)), {$urandom, $urandom}, 16'($urandom));
            default: apply_settings(4'd8, 64'd0, 16'($urandom));
         endcase
         resync_frame();
         // long receiver hold while items keep coming
         if (p == 5) hold_asked++;
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) send_random_frame();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (failures == 0 && deframed_q.size() == 0)
         $display("tb_signed_packet_deframer_crc16_unit OK");
      else
         $display("tb_signed_packet_deframer_crc16_unit NOT OK");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sdf_pkg.sv
rtl/core/sdf_queue.sv
rtl/core/sdf_engine.sv
rtl/core/signed_packet_deframer_crc16_unit.sv
test/tb_signed_packet_deframer_crc16_unit.sv
